>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/mpwm_pkg.sv
// Types and constants of the multichannel PWM generator.
package mpwm_pkg;

    localparam int PIN_W    = 5;
    localparam int DUTY_W   = 8;
    localparam int LEVELS_W = 8;
    localparam int BIT_W    = 4;
    localparam int PORT_W   = 2;

    localparam logic [PIN_W-1:0] PORT_A_LIMIT = PIN_W'(2);
    localparam logic [PIN_W-1:0] PORT_C_LIMIT = PIN_W'(10);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CONFIG = 2'd1,
        CMD_WRITE  = 2'd2
    } cmd_t;

    typedef enum logic [PORT_W-1:0] {
        PORT_A = 2'd0,
        PORT_C = 2'd1,
        PORT_D = 2'd2
    } port_t;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } ctl_state_t;

    // Command bundle from controller to datapath
    typedef struct packed {
        logic load;
        logic tick;
        logic alloc;
        logic write;
    } dp_ctrl_t;

endpackage

>>> design/mpwm_ctrl.sv
// Controller: handshake state machine and command decode.
module mpwm_ctrl
    import mpwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] command,
    output logic       res_valid,
    input  logic       res_stall,
    output dp_ctrl_t   ctrl
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        res_valid  = (state_reg == ST_FULL);
        cmd_stall  = (state_reg == ST_FULL) && res_stall;
        take       = cmd_valid && !cmd_stall;
        state_next = state_reg;
        ctrl       = '0;
        ctrl.load  = take;

        unique case (state_reg)
            ST_EMPTY:
            begin
                if (take)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!take && !res_stall)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase

        // Unused command code only refreshes the result
        unique case (cmd_t'(command))
            CMD_TICK:   ctrl.tick  = take;
            CMD_CONFIG: ctrl.alloc = take;
            CMD_WRITE:  ctrl.write = take;
            default:    ;
        endcase
    end

endmodule

>>> design/mpwm_datapath.sv
// Datapath: channel stores, tick counter, per-channel level lanes, result register.
module mpwm_datapath
    import mpwm_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_ctrl_t            ctrl,
    input  logic [PIN_W-1:0]    pin_number,
    input  logic [DUTY_W-1:0]   duty,
    output logic [LEVELS_W-1:0] levels,
    output logic                accepted,
    output logic [PORT_W-1:0]   port_select,
    output logic [BIT_W-1:0]    bit_index
);

    localparam int UW   = $clog2(CHANNELS + 1);
    localparam int PADW = (CHANNELS > LEVELS_W) ? CHANNELS : LEVELS_W;

    logic [DUTY_W-1:0]   duty_reg [CHANNELS];
    logic [PIN_W-1:0]    pin_reg  [CHANNELS];
    logic [DUTY_W-1:0]   tick_reg;
    logic [DUTY_W-1:0]   tick_next;
    logic [UW-1:0]       used_reg;
    logic [UW-1:0]       used_next;
    logic [CHANNELS-1:0] level_reg;
    logic [CHANNELS-1:0] level_next;
    logic [CHANNELS-1:0] live;
    logic [CHANNELS-1:0] slot;
    logic [CHANNELS-1:0] hit;
    logic [PADW-1:0]     level_pad;
    logic                full;
    logic                grant;
    logic [PIN_W-1:0]    bit_wide;
    port_t               port_sel;

    logic [LEVELS_W-1:0] levels_reg;
    logic                accepted_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [BIT_W-1:0]    bit_reg;

    assign full      = (used_reg == UW'(CHANNELS));
    assign grant     = ctrl.alloc && !full;
    assign tick_next = ctrl.tick ? tick_reg + DUTY_W'(1) : tick_reg;
    assign used_next = grant ? used_reg + UW'(1) : used_reg;

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            live[i] = (UW'(i) < used_reg);
            slot[i] = (UW'(i) == used_reg);
            hit[i]  = live[i] && (pin_reg[i] == pin_number);
        end
    end

    // Level lanes: each channel updates on its own
    always_comb
    begin
        level_next = level_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (ctrl.tick && live[i])
            begin
                if (tick_next == '0)
                begin
                    level_next[i] = (duty_reg[i] != '0);
                end
                else if (duty_reg[i] < tick_next)
                begin
                    level_next[i] = 1'b0;
                end
            end
            else if (grant && slot[i])
            begin
                level_next[i] = 1'b0;
            end
        end
    end

    assign level_pad = PADW'(level_next);

    always_comb
    begin
        if (pin_number < PORT_A_LIMIT)
        begin
            port_sel = PORT_A;
            bit_wide = pin_number;
        end
        else if (pin_number < PORT_C_LIMIT)
        begin
            port_sel = PORT_C;
            bit_wide = pin_number - PORT_A_LIMIT;
        end
        else
        begin
            port_sel = PORT_D;
            bit_wide = pin_number - PORT_C_LIMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            used_reg  <= '0;
            level_reg <= '0;
        end
        else if (ctrl.load)
        begin
            tick_reg  <= tick_next;
            used_reg  <= used_next;
            level_reg <= level_next;
        end
    end

    // Stores are always written at allocation before any read
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (grant && slot[i])
            begin
                pin_reg[i]  <= pin_number;
                duty_reg[i] <= '0;
            end
            else if (ctrl.write && hit[i])
            begin
                duty_reg[i] <= duty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            levels_reg   <= level_pad[LEVELS_W-1:0];
            accepted_reg <= grant;
            port_reg     <= grant ? port_sel : PORT_A;
            bit_reg      <= grant ? bit_wide[BIT_W-1:0] : '0;
        end
    end

    assign levels      = levels_reg;
    assign accepted    = accepted_reg;
    assign port_select = port_reg;
    assign bit_index   = bit_reg;

endmodule

>>> design/multichannel_pwm_generator.sv
// Multichannel PWM generator: top level.
// Usage:
//   Command channel (cmd_valid/cmd_stall) carries command, pin_number, duty.
//   tick advances the 8-bit counter and refreshes every allocated channel;
//   configure binds the next free channel to a pin and reports its port/bit;
//   write sets the duty of all allocated channels bound to pin_number.
//   Result channel (res_valid/res_stall) returns one item per command:
//   levels (channels 0..7), accepted, port_select, bit_index.
// Timing:
//   The result is registered at the edge that takes the command. One
//   command per cycle while cmd_stall is low; all channel lanes update in
//   that cycle and the result register holds the item until it is taken.
//   While the result waits under res_stall, cmd_stall is raised; a command
//   is taken in the same cycle the waiting result leaves.
// Reset:
//   rst_n clears the counter, channel count and levels; no channel is
//   allocated and no result is pending. No setup pass is needed.
module multichannel_pwm_generator
    import mpwm_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [1:0]          command,
    input  logic [PIN_W-1:0]    pin_number,
    input  logic [DUTY_W-1:0]   duty,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [LEVELS_W-1:0] levels,
    output logic                accepted,
    output logic [PORT_W-1:0]   port_select,
    output logic [BIT_W-1:0]    bit_index
);

`include "assert_macros.svh"

    dp_ctrl_t ctrl;

    mpwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctrl      (ctrl)
    );

    mpwm_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .pin_number  (pin_number),
        .duty        (duty),
        .levels      (levels),
        .accepted    (accepted),
        .port_select (port_select),
        .bit_index   (bit_index)
    );

    `ASSERT_SAME(a_stall_only_when_blocked, cmd_stall, res_valid && res_stall)
    `ASSERT_NEXT(a_item_gives_result, cmd_valid && !cmd_stall, res_valid)
    `ASSERT_NEXT(a_no_spurious_result, res_valid && !res_stall && !cmd_valid, !res_valid)
    `ASSERT_SAME(a_reject_fields_zero, res_valid && !accepted, port_select == PORT_A && bit_index == '0)

endmodule

>>> dv/multichannel_pwm_generator_tb.sv
// Self-checking testbench for the multichannel PWM generator.
module multichannel_pwm_generator_tb;
    import mpwm_pkg::*;

    localparam int NUM_CH = 8;
    localparam int RANDOM_ITEMS = 190;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic                accepted;
        port_t               port_sel;
        logic [BIT_W-1:0]    bit_idx;
    } pwm_result_t;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    logic [1:0]          command;
    logic [PIN_W-1:0]    pin_number;
    logic [DUTY_W-1:0]   duty;
    logic                res_valid;
    logic                res_stall;
    logic [LEVELS_W-1:0] levels;
    logic                accepted;
    logic [PORT_W-1:0]   port_select;
    logic [BIT_W-1:0]    bit_index;

    // predictor state
    logic [7:0]        tick_cnt;
    logic [DUTY_W-1:0] duty_mem [NUM_CH];
    logic [PIN_W-1:0]  pin_mem [NUM_CH];
    int unsigned       alloc_cnt;
    logic [NUM_CH-1:0] level_mask;

    pwm_result_t pending_results [$];
    int unsigned err_count = 0;
    int unsigned burst_left = 0;
    bit          hold_req = 1'b0;

    multichannel_pwm_generator #(.CHANNELS(NUM_CH)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .pin_number  (pin_number),
        .duty        (duty),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .levels      (levels),
        .accepted    (accepted),
        .port_select (port_select),
        .bit_index   (bit_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pwm_result_t predict_pwm_step(
        logic [1:0] c, logic [PIN_W-1:0] p, logic [DUTY_W-1:0] d);
        pwm_result_t r;
        r = '0;
        case (c)
            CMD_TICK:
            begin
                tick_cnt = tick_cnt + 8'd1;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (i < alloc_cnt)
                    begin
                        if (tick_cnt == 8'd0)
                            level_mask[i] = (duty_mem[i] != '0);
                        else if (duty_mem[i] < tick_cnt)
                            level_mask[i] = 1'b0;
                    end
                end
            end
            CMD_CONFIG:
            begin
                if (alloc_cnt < NUM_CH)
                begin
                    pin_mem[alloc_cnt] = p;
                    duty_mem[alloc_cnt] = '0;
                    level_mask[alloc_cnt] = 1'b0;
                    alloc_cnt++;
                    r.accepted = 1'b1;
                    if (p < PORT_A_LIMIT)
                    begin
                        r.port_sel = PORT_A;
                        r.bit_idx = BIT_W'(p);
                    end
                    else if (p < PORT_C_LIMIT)
                    begin
                        r.port_sel = PORT_C;
                        r.bit_idx = BIT_W'(p - PORT_A_LIMIT);
                    end
                    else
                    begin
                        r.port_sel = PORT_D;
                        r.bit_idx = BIT_W'(p - PORT_C_LIMIT);
                    end
                end
            end
            CMD_WRITE:
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (i < alloc_cnt && pin_mem[i] == p)
                        duty_mem[i] = d;
                end
            end
            default: ;
        endcase
        r.levels = LEVELS_W'(level_mask);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        err_count++;
    endtask

    // Sender idles between most bursts; a zero gap keeps valid high across items.
    task automatic send_item(input logic [1:0] c, input logic [PIN_W-1:0] p,
                             input logic [DUTY_W-1:0] d);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_valid  <= 1'b1;
        command    <= c;
        pin_number <= p;
        duty       <= d;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pending_results.push_back(predict_pwm_step(c, p, d));
    endtask

    task automatic send_random_item();
        int unsigned roll;
        logic [1:0] c;
        logic [PIN_W-1:0] p;
        logic [DUTY_W-1:0] d;
        roll = $urandom_range(0, 99);
        p = PIN_W'($urandom_range(0, 31));
        d = DUTY_W'($urandom);
        if (roll < 75)
            c = CMD_TICK;
        else if (roll < 95)
        begin
            c = CMD_WRITE;
            if (alloc_cnt != 0 && $urandom_range(0, 4) != 0)
                p = pin_mem[$urandom_range(0, alloc_cnt - 1)];
            case ($urandom_range(0, 7))
                0: d = '0;
                1: d = '1;
                default: ;
            endcase
        end
        else if (roll < 97)
            c = CMD_CONFIG;
        else
            c = CMD_RESERVED;
        send_item(c, p, d);
    endtask

    task automatic test_configure_channels();
        // ninth configure finds no free channel; pin 10 is bound twice
        send_item(CMD_CONFIG, 5'd0, 8'd0);
        send_item(CMD_CONFIG, 5'd1, 8'd255);
        send_item(CMD_CONFIG, 5'd2, 8'd0);
        send_item(CMD_CONFIG, 5'd9, 8'd0);
        send_item(CMD_CONFIG, 5'd10, 8'd0);
        send_item(CMD_CONFIG, 5'd17, 8'd0);
        send_item(CMD_CONFIG, 5'd31, 8'd0);
        send_item(CMD_CONFIG, 5'd10, 8'd0);
        send_item(CMD_CONFIG, 5'd5, 8'd0);
    endtask

    task automatic test_duty_writes();
        send_item(CMD_WRITE, 5'd0, 8'd0);
        send_item(CMD_WRITE, 5'd31, 8'd255);
        send_item(CMD_WRITE, 5'd10, 8'd128);
        send_item(CMD_WRITE, 5'd1, 8'd1);
        send_item(CMD_WRITE, 5'd2, 8'd254);
        send_item(CMD_WRITE, 5'd17, 8'd85);
        send_item(CMD_WRITE, 5'd9, 8'd170);
        send_item(CMD_WRITE, 5'd20, 8'd42);   // no channel on this pin
    endtask

    task automatic test_reserved_command();
        send_item(CMD_RESERVED, 5'd31, 8'd255);
        send_item(CMD_RESERVED, 5'd0, 8'd0);
    endtask

    task automatic test_ticks();
        repeat (4) send_item(CMD_TICK, 5'd0, 8'd0);
    endtask

    task automatic test_random_traffic();
        repeat (RANDOM_ITEMS) send_random_item();
    endtask

    task automatic test_input_backpressure();
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS) send_random_item();
    endtask

    // receiver: free-running stall pattern, or one long hold-off on request
    initial
    begin
        int unsigned phase;
        res_stall = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else
            begin
                phase = (phase + 1) % 96;
                res_stall <= (phase >= 32) && ($urandom_range(0, 2) == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        pwm_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected item, levels", 0, levels);
            else
            begin
                want = pending_results.pop_front();
                if (levels !== want.levels)
                    report_mismatch("levels", want.levels, levels);
                if (accepted !== want.accepted)
                    report_mismatch("accepted", want.accepted, accepted);
                if (port_select !== want.port_sel)
                    report_mismatch("port_select", want.port_sel, port_select);
                if (bit_index !== want.bit_idx)
                    report_mismatch("bit_index", want.bit_idx, bit_index);
            end
        end
    end

    always @(posedge clk)
    begin
        int unsigned quiet_cycles;
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        command    = CMD_TICK;
        pin_number = '0;
        duty       = '0;
        tick_cnt   = '0;
        alloc_cnt  = 0;
        level_mask = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            duty_mem[i] = '0;
            pin_mem[i]  = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reserved_command();
        test_ticks();
        test_configure_channels();
        test_duty_writes();
        test_ticks();
        test_random_traffic();
        test_input_backpressure();
        test_random_traffic();

        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/mpwm_pkg.sv
design/mpwm_ctrl.sv
design/mpwm_datapath.sv
design/multichannel_pwm_generator.sv
dv/multichannel_pwm_generator_tb.sv
